FILE: rtl/core/ccrm_pkg.sv
// Shared types and constants of the compressed code record matcher.
`default_nettype none

package ccrm_pkg;

   // Record geometry.
   localparam int MaxEntries = 16;
   localparam int StoreDepth = MaxEntries - 1;
   localparam int MinEntries = 3;

   // Field widths.
   localparam int ByteWidth = 8;
   localparam int CountWidth = 5;
   localparam int MagWidth = 60;
   localparam int SignWidth = 16;
   localparam int EntryWidth = 5;
   localparam int IndexWidth = 32;
   localparam int LastWidth = 9;
   localparam int CsrDataWidth = MagWidth;
   localparam int CsrIndexWidth = 2;

   // Reciprocal of 17 for an 8-bit dividend: floor(b / 17) = (b * 241) >> 12.
   localparam logic [15:0] Recip17 = 16'd241;
   localparam int Recip17Shift = 12;

   // Configuration register indexes.
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_NUM_CROSSINGS     = 2'd0,
      CSR_TARGET_MAGNITUDES = 2'd1,
      CSR_TARGET_SIGNS      = 2'd2
   } csr_index_type;

   // Parser phases, one-hot.
   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_BODY   = 4'b0010,
      PH_SIGN1  = 4'b0100,
      PH_SIGN2  = 4'b1000
   } parse_phase_type;

   // Payload types.
   typedef logic [ByteWidth-1:0] data_byte_type;
   typedef logic [IndexWidth-1:0] record_index_type;
   typedef logic signed [LastWidth-1:0] last_entry_type;
   typedef logic [EntryWidth-1:0] entry_type;

endpackage : ccrm_pkg

`default_nettype wire

FILE: rtl/core/ccrm_req_if.sv
// Input byte channel of the compressed code record matcher.
`default_nettype none

interface ccrm_req_if;
   logic valid;
   logic ready;
   ccrm_pkg::data_byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface : ccrm_req_if

`default_nettype wire

FILE: rtl/core/ccrm_rsp_if.sv
// Result channel of the compressed code record matcher.
`default_nettype none

interface ccrm_rsp_if;
   logic valid;
   logic ready;
   ccrm_pkg::record_index_type record_index;
   ccrm_pkg::last_entry_type last_entry;

   modport source (output valid, output record_index, output last_entry, input ready);
   modport sink (input valid, input record_index, input last_entry, output ready);
endinterface : ccrm_rsp_if

`default_nettype wire

FILE: rtl/core/compressed_code_record_matcher_unit.sv
// Top level of the compressed code record matcher: parser, entry store and match logic.
`default_nettype none

// Usage:
// The req_chan sink takes one byte of the prefix-compressed record stream per
// transaction. Each record is a header byte, zero or more body bytes and two sign
// bytes. When the second sign byte completes a record whose entries and signs equal
// the configured target, one transaction leaves on rsp_chan with the one-based
// record number and the signed, doubled derived last entry.
// Throughput is one byte per cycle while req_chan.ready is high: the parser, the
// entry compares and the entry sum all settle combinationally from the registered
// record state. The result register is loaded at the edge that accepts the second
// sign byte and rsp_chan.valid is high in the following cycle.
// When the receiver stalls, the result waits in the output register; req_chan.ready
// stays high as long as that register is empty or is being emptied in the same cycle.
// The csr_ port writes num_crossings, target_magnitudes and target_signs; the user
// must write it only while the block is idle. The block itself does not enforce this.
// Synchronous active-high reset restores the register defaults, clears the entry
// store, the record counter and the parser, and drops any pending result.

module compressed_code_record_matcher_unit (
   input  wire logic clock,
   input  wire logic reset,
   ccrm_req_if.sink req_chan,
   ccrm_rsp_if.source rsp_chan,
   input  wire logic csr_write_enable,
   input  wire logic [ccrm_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [ccrm_pkg::CsrDataWidth-1:0] csr_write_data
);

   // Configuration registers.
   logic [ccrm_pkg::CountWidth-1:0] num_crossings_ff;
   logic [ccrm_pkg::MagWidth-1:0] target_magnitudes_ff;
   logic [ccrm_pkg::SignWidth-1:0] target_signs_ff;

   // Record state.
   ccrm_pkg::entry_type entry_store_ff [ccrm_pkg::StoreDepth];
   ccrm_pkg::entry_type entry_store_in [ccrm_pkg::StoreDepth];
   ccrm_pkg::parse_phase_type phase_ff, phase_in;
   logic [3:0] body_position_ff, body_position_in;
   ccrm_pkg::data_byte_type first_sign_byte_ff, first_sign_byte_in;
   ccrm_pkg::record_index_type record_counter_ff, record_counter_in;

   // Result register.
   logic rsp_valid_ff, rsp_valid_in;
   ccrm_pkg::record_index_type rsp_record_ff, rsp_record_in;
   ccrm_pkg::last_entry_type rsp_last_ff, rsp_last_in;

   // Datapath signals.
   logic req_ready;
   logic accept;
   ccrm_pkg::data_byte_type in_byte;
   logic [ccrm_pkg::CountWidth-1:0] count_n;
   logic [ccrm_pkg::CountWidth-1:0] count_n_m1;
   logic [15:0] kept_prod;
   logic [3:0] kept;
   logic [ccrm_pkg::CountWidth-1:0] offset;
   logic [ccrm_pkg::CountWidth-1:0] pos_ext;
   logic wr_hi;
   logic wr_lo;
   logic body_done;
   ccrm_pkg::entry_type hi_value;
   ccrm_pkg::entry_type lo_value;
   logic [ccrm_pkg::SignWidth-1:0] signs;
   logic [ccrm_pkg::SignWidth-1:0] sign_mask;
   logic [ccrm_pkg::CountWidth-1:0] sign_pos;
   logic last_positive;
   logic [ccrm_pkg::StoreDepth-1:0] entry_ok;
   logic record_match;
   ccrm_pkg::entry_type masked_entry [ccrm_pkg::StoreDepth];
   logic [6:0] group_sum [4];
   logic [7:0] entry_sum;
   logic [9:0] tri_prod;
   logic [7:0] tri_value;
   logic signed [9:0] last_value;
   logic signed [10:0] last_doubled;

   // Handshake: a byte is taken whenever the result register is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = req_ready;
   assign accept = req_chan.valid && req_ready;
   assign in_byte = req_chan.data_byte;

   // Effective entry count, saturated to the supported range.
   always_comb begin
      if (num_crossings_ff < ccrm_pkg::CountWidth'(ccrm_pkg::MinEntries)) begin
         count_n = ccrm_pkg::CountWidth'(ccrm_pkg::MinEntries);
      end else if (num_crossings_ff > ccrm_pkg::CountWidth'(ccrm_pkg::MaxEntries)) begin
         count_n = ccrm_pkg::CountWidth'(ccrm_pkg::MaxEntries);
      end else begin
         count_n = num_crossings_ff;
      end
   end
   assign count_n_m1 = count_n - 5'd1;

   // Header decode: kept count is the header divided by 17.
   assign kept_prod = {8'd0, in_byte} * ccrm_pkg::Recip17;
   assign kept = kept_prod[15:ccrm_pkg::Recip17Shift];
   assign offset = ({1'b0, kept} > count_n_m1) ? 5'd0 : (count_n_m1 - {1'b0, kept});

   // Body decode: two nibble entries per byte, dropped past the derived entry.
   assign pos_ext = {1'b0, body_position_ff};
   assign wr_hi = (pos_ext + 5'd1) < count_n;
   assign wr_lo = (pos_ext + 5'd2) < count_n;
   assign body_done = ({1'b0, pos_ext} + 6'd3) >= {1'b0, count_n};
   assign hi_value = {1'b0, in_byte[7:4]} + 5'd1;
   assign lo_value = {1'b0, in_byte[3:0]} + 5'd1;

   // Parser next state.
   always_comb begin
      phase_in = phase_ff;
      body_position_in = body_position_ff;
      first_sign_byte_in = first_sign_byte_ff;
      record_counter_in = record_counter_ff;
      for (int i = 0; i < ccrm_pkg::StoreDepth; i++) begin
         entry_store_in[i] = entry_store_ff[i];
      end
      if (accept) begin
         unique case (phase_ff)
            ccrm_pkg::PH_HEADER: begin
               record_counter_in = record_counter_ff + 32'd1;
               if (offset == count_n_m1) begin
                  phase_in = ccrm_pkg::PH_SIGN1;
               end else begin
                  body_position_in = offset[3:0];
                  phase_in = ccrm_pkg::PH_BODY;
               end
            end
            ccrm_pkg::PH_BODY: begin
               for (int i = 0; i < ccrm_pkg::StoreDepth; i++) begin
                  if (wr_hi && (body_position_ff == 4'(i))) begin
                     entry_store_in[i] = hi_value;
                  end
                  if (wr_lo && ((pos_ext + 5'd1) == 5'(i))) begin
                     entry_store_in[i] = lo_value;
                  end
               end
               if (body_done) begin
                  phase_in = ccrm_pkg::PH_SIGN1;
                  body_position_in = 4'd0;
               end else begin
                  body_position_in = body_position_ff + 4'd2;
               end
            end
            ccrm_pkg::PH_SIGN1: begin
               first_sign_byte_in = in_byte;
               phase_in = ccrm_pkg::PH_SIGN2;
            end
            ccrm_pkg::PH_SIGN2: begin
               phase_in = ccrm_pkg::PH_HEADER;
            end
            default: begin
               phase_in = ccrm_pkg::PH_HEADER;
            end
         endcase
      end
   end

   // Sign word of the record and the mask of its first n bits.
   assign signs = {first_sign_byte_ff, in_byte};
   assign sign_mask = ~(16'hFFFF >> count_n);
   assign sign_pos = 5'd16 - count_n;
   assign last_positive = signs[sign_pos[3:0]];

   // Per-entry compare against the target and masking of unused entries.
   always_comb begin
      for (int i = 0; i < ccrm_pkg::StoreDepth; i++) begin
         if ((5'(i) + 5'd1) < count_n) begin
            entry_ok[i] = entry_store_ff[i] ==
                          ({1'b0, target_magnitudes_ff[4*i +: 4]} + 5'd1);
            masked_entry[i] = entry_store_ff[i];
         end else begin
            entry_ok[i] = 1'b1;
            masked_entry[i] = '0;
         end
      end
   end
   assign record_match = (&entry_ok) && ((signs & sign_mask) == (target_signs_ff & sign_mask));

   // Entry sum as a two-level tree of groups of up to four entries.
   always_comb begin
      for (int g = 0; g < 4; g++) begin
         group_sum[g] = '0;
         for (int k = 0; k < 4; k++) begin
            if ((4 * g + k) < ccrm_pkg::StoreDepth) begin
               group_sum[g] = group_sum[g] + {2'b0, masked_entry[4 * g + k]};
            end
         end
      end
   end
   assign entry_sum = {1'b0, group_sum[0]} + {1'b0, group_sum[1]} +
                      {1'b0, group_sum[2]} + {1'b0, group_sum[3]};

   // Derived last entry: triangular number minus the sum, doubled and signed.
   assign tri_prod = {5'd0, count_n} * ({5'd0, count_n} + 10'd1);
   assign tri_value = tri_prod[8:1];
   assign last_value = $signed({2'b0, tri_value}) - $signed({2'b0, entry_sum});
   assign last_doubled = last_positive ? $signed({last_value, 1'b0})
                                       : -$signed({last_value, 1'b0});

   // Result register next state.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_record_in = rsp_record_ff;
      rsp_last_in = rsp_last_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && (phase_ff == ccrm_pkg::PH_SIGN2) && record_match) begin
         rsp_valid_in = 1'b1;
         rsp_record_in = record_counter_ff;
         rsp_last_in = last_doubled[ccrm_pkg::LastWidth-1:0];
      end
   end

   // Control and record state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_crossings_ff <= ccrm_pkg::CountWidth'(ccrm_pkg::MaxEntries);
         target_magnitudes_ff <= '0;
         target_signs_ff <= '0;
         phase_ff <= ccrm_pkg::PH_HEADER;
         body_position_ff <= '0;
         first_sign_byte_ff <= '0;
         record_counter_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ccrm_pkg::StoreDepth; i++) begin
            entry_store_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               ccrm_pkg::CSR_NUM_CROSSINGS: begin
                  num_crossings_ff <= csr_write_data[ccrm_pkg::CountWidth-1:0];
               end
               ccrm_pkg::CSR_TARGET_MAGNITUDES: begin
                  target_magnitudes_ff <= csr_write_data[ccrm_pkg::MagWidth-1:0];
               end
               ccrm_pkg::CSR_TARGET_SIGNS: begin
                  target_signs_ff <= csr_write_data[ccrm_pkg::SignWidth-1:0];
               end
               default: begin
               end
            endcase
         end
         phase_ff <= phase_in;
         body_position_ff <= body_position_in;
         first_sign_byte_ff <= first_sign_byte_in;
         record_counter_ff <= record_counter_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ccrm_pkg::StoreDepth; i++) begin
            entry_store_ff[i] <= entry_store_in[i];
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      rsp_record_ff <= rsp_record_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.record_index = rsp_record_ff;
   assign rsp_chan.last_entry = rsp_last_ff;

`ifndef SYNTHESIS
   // A matching second sign byte loads the result with the current record number.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == ccrm_pkg::PH_SIGN2) && record_match) |=>
         (rsp_valid_ff && (rsp_record_ff == $past(record_counter_ff))))
      else $error("matched record did not load the result register");

   // A new result only appears as the parser returns to the header phase.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (phase_ff == ccrm_pkg::PH_HEADER))
      else $error("result appeared outside the end of a record");

   // Every accepted header byte counts exactly one record.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == ccrm_pkg::PH_HEADER)) |=>
         (record_counter_ff == ($past(record_counter_ff) + 32'd1)))
      else $error("record counter did not advance on a header byte");
`endif

endmodule : compressed_code_record_matcher_unit

`default_nettype wire

FILE: test/compressed_code_record_matcher_unit_tb.sv
// Self-checking testbench of the compressed code record matcher: directed and random byte streams.
module compressed_code_record_matcher_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 200000;
   localparam int HoldOffCycles = 40;
   localparam int SettleCycles = 4;
   localparam int PhaseBytes = 92;

   // One expected match: record number and doubled signed last entry.
   typedef struct {
      ccrm_pkg::record_index_type record_index;
      ccrm_pkg::last_entry_type last_entry;
   } record_match_type;

   // Scoreboard: follows the parser on accepted bytes and holds the matches it predicts.
   class record_match_scoreboard;
      logic [ccrm_pkg::CountWidth-1:0] count_setting;
      logic [ccrm_pkg::MagWidth-1:0] magnitude_target;
      logic [ccrm_pkg::SignWidth-1:0] sign_target;
      ccrm_pkg::entry_type entries [ccrm_pkg::StoreDepth];
      ccrm_pkg::parse_phase_type phase;
      logic [3:0] body_position;
      ccrm_pkg::data_byte_type first_signs;
      ccrm_pkg::record_index_type records_seen;
      record_match_type expected_matches[$];
      int failures;

      function void reset_state();
         count_setting = ccrm_pkg::CountWidth'(ccrm_pkg::MaxEntries);
         magnitude_target = '0;
         sign_target = '0;
         foreach (entries[i]) entries[i] = '0;
         phase = ccrm_pkg::PH_HEADER;
         body_position = '0;
         first_signs = '0;
         records_seen = '0;
         expected_matches.delete();
         failures = 0;
      endfunction

      function void write_register(ccrm_pkg::csr_index_type which,
                                   logic [ccrm_pkg::CsrDataWidth-1:0] data);
         case (which)
            ccrm_pkg::CSR_NUM_CROSSINGS:
               count_setting = data[ccrm_pkg::CountWidth-1:0];
            ccrm_pkg::CSR_TARGET_MAGNITUDES:
               magnitude_target = data[ccrm_pkg::MagWidth-1:0];
            ccrm_pkg::CSR_TARGET_SIGNS:
               sign_target = data[ccrm_pkg::SignWidth-1:0];
            default: ;
         endcase
      endfunction

      // Entries per record, with the register clamped to the supported range.
      function int unsigned entry_count();
         int unsigned n;
         n = count_setting;
         if (n < ccrm_pkg::MinEntries) n = ccrm_pkg::MinEntries;
         if (n > ccrm_pkg::MaxEntries) n = ccrm_pkg::MaxEntries;
         return n;
      endfunction

      function int unsigned pending();
         return expected_matches.size();
      endfunction

      // Advance the parser by one accepted byte; queue a match when a record completes.
      function void note_byte(ccrm_pkg::data_byte_type value);
         int unsigned n, kept, offset, pos, sum, i;
         logic [15:0] signs, mask;
         bit matched;
         int last_value, doubled;
         record_match_type hit;
         n = entry_count();
         case (phase)
            ccrm_pkg::PH_HEADER: begin
               kept = value / 17;
               offset = (kept > n - 1) ? 0 : n - 1 - kept;
               records_seen = records_seen + 1;
               if (offset >= n - 1) begin
                  phase = ccrm_pkg::PH_SIGN1;
               end else begin
                  body_position = 4'(offset);
                  phase = ccrm_pkg::PH_BODY;
               end
            end
            ccrm_pkg::PH_BODY: begin
               pos = body_position;
               // The second nibble never lands on the derived last entry.
               if (pos + 1 < n) entries[pos] = ccrm_pkg::entry_type'(int'(value[7:4]) + 1);
               if (pos + 2 < n) entries[pos + 1] = ccrm_pkg::entry_type'(int'(value[3:0]) + 1);
               if (pos + 3 >= n) begin
                  phase = ccrm_pkg::PH_SIGN1;
                  body_position = '0;
               end else begin
                  body_position = 4'(pos + 2);
               end
            end
            ccrm_pkg::PH_SIGN1: begin
               first_signs = value;
               phase = ccrm_pkg::PH_SIGN2;
            end
            ccrm_pkg::PH_SIGN2: begin
               phase = ccrm_pkg::PH_HEADER;
               signs = {first_signs, value};
               mask = 16'hFFFF << (16 - n);
               matched = ((signs & mask) == (sign_target & mask));
               sum = 0;
               for (i = 0; i + 1 < n; i++) begin
                  if (int'(entries[i]) != int'(magnitude_target[4*i +: 4]) + 1) matched = 1'b0;
                  sum += entries[i];
               end
               if (matched) begin
                  last_value = int'(n * (n + 1) / 2) - int'(sum);
                  doubled = signs[16 - n] ? 2 * last_value : -2 * last_value;
                  hit.record_index = records_seen;
                  hit.last_entry = ccrm_pkg::last_entry_type'(doubled);
                  expected_matches.push_back(hit);
               end
            end
            default: phase = ccrm_pkg::PH_HEADER;
         endcase
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         failures++;
      endtask

      // Compare one accepted result transaction with the oldest predicted match.
      task check_result(ccrm_pkg::record_index_type got_index,
                        ccrm_pkg::last_entry_type got_last);
         record_match_type want;
         if (expected_matches.size() == 0) begin
            report($sformatf("result with no match pending: record %0d last entry %0d",
                             got_index, got_last));
         end else begin
            want = expected_matches.pop_front();
            if (got_index !== want.record_index)
               report($sformatf("record_index %0d, predicted %0d", got_index, want.record_index));
            if (got_last !== want.last_entry)
               report($sformatf("last_entry %0d, predicted %0d (record %0d)",
                                got_last, want.last_entry, want.record_index));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [ccrm_pkg::CsrIndexWidth-1:0] csr_index;
   logic [ccrm_pkg::CsrDataWidth-1:0] csr_write_data;
   int send_idle_pct;
   int stall_pct;
   int holds_asked;
   int cycle_count;
   int bytes_sent;
   record_match_scoreboard records;

   ccrm_req_if req_bus ();
   ccrm_rsp_if rsp_bus ();

   compressed_code_record_matcher_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // 12 ns clock.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Run limit.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   initial begin : receiver
      int holds_served;
      int held;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            holds_served++;
            rsp_bus.ready <= 1'b0;
            for (held = 0; held < HoldOffCycles; held++) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Check every result transaction as it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         records.check_result(rsp_bus.record_index, rsp_bus.last_entry);
   end

   function automatic logic [ccrm_pkg::CsrDataWidth-1:0] random_word();
      return ccrm_pkg::CsrDataWidth'({$urandom, $urandom});
   endfunction

   // Offer one byte, with random idle cycles ahead of it, and note it once accepted.
   task automatic send_byte(input ccrm_pkg::data_byte_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= value;
      do @(posedge clock); while (!req_bus.ready);
      records.note_byte(value);
      bytes_sent++;
   endtask

   // Stop sending and wait until every predicted match has come out and the block is quiet.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (records.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write all three registers on consecutive cycles.
   task automatic apply_settings(input logic [ccrm_pkg::CsrDataWidth-1:0] count_word,
                                 input logic [ccrm_pkg::CsrDataWidth-1:0] magnitudes,
                                 input logic [ccrm_pkg::CsrDataWidth-1:0] sign_word);
      csr_write_enable <= 1'b1;
      csr_index <= ccrm_pkg::CSR_NUM_CROSSINGS;
      csr_write_data <= count_word;
      @(posedge clock);
      records.write_register(ccrm_pkg::CSR_NUM_CROSSINGS, count_word);
      csr_index <= ccrm_pkg::CSR_TARGET_MAGNITUDES;
      csr_write_data <= magnitudes;
      @(posedge clock);
      records.write_register(ccrm_pkg::CSR_TARGET_MAGNITUDES, magnitudes);
      csr_index <= ccrm_pkg::CSR_TARGET_SIGNS;
      csr_write_data <= sign_word;
      @(posedge clock);
      records.write_register(ccrm_pkg::CSR_TARGET_SIGNS, sign_word);
      csr_write_enable <= 1'b0;
   endtask

   // One well-formed record; when aimed at a match, the new entries and signs follow the target, bar a rare sign flip.
   task automatic send_record(input bit aim_match);
      int unsigned n, kept, offset, body_bytes, j, e, flip;
      logic [7:0] header;
      logic [3:0] hi, lo;
      logic [15:0] mask, signs;
      n = records.entry_count();
      if (aim_match) begin
         case ($urandom_range(3))
            0: kept = n - 1;
            1: kept = 0;
            default: kept = $urandom_range(n - 1, 1);
         endcase
         header = 8'(kept * 17 + $urandom_range((255 - kept * 17 < 16) ? 255 - kept * 17 : 16, 0));
         // A count past the record length means every entry is rewritten.
         if (n < ccrm_pkg::MaxEntries && $urandom_range(3) == 0) begin
            header = 8'($urandom_range(255, n * 17));
         end
      end else begin
         header = 8'($urandom_range(255));
      end
      kept = header / 17;
      offset = (kept > n - 1) ? 0 : n - 1 - kept;
      body_bytes = (n - offset) / 2;
      send_byte(header);
      for (j = 0; j < body_bytes; j++) begin
         e = offset + 2 * j;
         if (aim_match) begin
            hi = records.magnitude_target[4*e +: 4];
            lo = (e + 2 < n) ? records.magnitude_target[4*(e+1) +: 4] : 4'($urandom);
            send_byte({hi, lo});
         end else begin
            send_byte(8'($urandom));
         end
      end
      mask = 16'hFFFF << (16 - n);
      signs = 16'($urandom);
      if (aim_match) begin
         signs = (records.sign_target & mask) | (signs & ~mask);
         if ($urandom_range(7) == 0) begin
            flip = $urandom_range(15, 16 - n);
            signs[flip] = ~signs[flip];
         end
      end
      send_byte(signs[15:8]);
      send_byte(signs[7:0]);
   endtask

   // Random bytes with no regard to record boundaries, then random bytes up to the next header.
   task automatic send_scrambled(input int unsigned count);
      repeat (count) send_byte(8'($urandom));
      while (records.phase != ccrm_pkg::PH_HEADER) send_byte(8'($urandom));
   endtask

   initial begin : stimulus
      ccrm_pkg::data_byte_type opening[] = '{8'h00, 8'h00, 8'h00,
                                   8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 8'h00, 8'h00,
                                   8'h11, 8'h0F, 8'hFF, 8'hFF};
      logic [ccrm_pkg::CsrDataWidth-1:0] count_word, magnitudes, sign_word;
      int phase_no, phase_start, choice;
      records = new();
      records.reset_state();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      rsp_bus.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = ccrm_pkg::CSR_NUM_CROSSINGS;
      csr_write_data = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      holds_asked = 0;
      bytes_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: empty body, a full record of ones that matches, a one-entry update.
      foreach (opening[i]) send_byte(opening[i]);

      // Count register below range, so three entries; header count larger than the record.
      wait_idle();
      magnitudes = random_word();
      count_word = random_word();
      count_word[ccrm_pkg::CountWidth-1:0] = '0;
      apply_settings(count_word, magnitudes, random_word());
      send_byte(8'hFF);
      send_byte({magnitudes[3:0], magnitudes[7:4]});
      send_byte(records.sign_target[15:8]);
      send_byte(records.sign_target[7:0]);

      // Entry count lowered in the middle of a body: the next body byte ends the body.
      wait_idle();
      apply_settings(ccrm_pkg::CsrDataWidth'(ccrm_pkg::MaxEntries), magnitudes, random_word());
      send_byte(8'd238);
      send_byte(8'($urandom));
      wait_idle();
      apply_settings(ccrm_pkg::CsrDataWidth'(4), magnitudes, random_word());
      send_scrambled(1);

      // Random phases, each with its own settings and one of four idle profiles.
      for (phase_no = 0; phase_no < 8; phase_no++) begin
         wait_idle();
         case (phase_no % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 62; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 62; end
            default: begin send_idle_pct = 31; stall_pct <= 31; end
         endcase
         count_word = random_word();
         case (phase_no)
            0: count_word[ccrm_pkg::CountWidth-1:0] = ccrm_pkg::CountWidth'(ccrm_pkg::MaxEntries);
            1: count_word[ccrm_pkg::CountWidth-1:0] = ccrm_pkg::CountWidth'(ccrm_pkg::MinEntries);
            2: count_word[ccrm_pkg::CountWidth-1:0] = '0;
            3: count_word[ccrm_pkg::CountWidth-1:0] = '1;
            default: begin
               count_word[ccrm_pkg::CountWidth-1:0] =
                  ccrm_pkg::CountWidth'($urandom_range(31, 1));
            end
         endcase
         case (phase_no)
            4: magnitudes = '1;
            5: magnitudes = '0;
            default: magnitudes = random_word();
         endcase
         sign_word = random_word();
         if (phase_no == 6) sign_word[ccrm_pkg::SignWidth-1:0] = '1;
         apply_settings(count_word, magnitudes, sign_word);

         // Receiver holds off while matching records keep arriving, so the input backs up.
         if (phase_no == 0) begin
            holds_asked <= holds_asked + 1;
            repeat (8) send_record(1'b1);
         end

         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PhaseBytes) begin
            choice = $urandom_range(99);
            if (choice < 70) send_record(1'b1);
            else if (choice < 88) send_record(1'b0);
            else send_scrambled($urandom_range(6, 1));
         end
      end

      wait_idle();
      if (records.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

FILE: files.f
rtl/core/ccrm_pkg.sv
rtl/core/ccrm_req_if.sv
rtl/core/ccrm_rsp_if.sv
rtl/core/compressed_code_record_matcher_unit.sv
test/compressed_code_record_matcher_unit_tb.sv
